// ----- rtl/fde_pkg.sv -----
// ----------------------------------------------------------------------------
// fde_pkg
// Types and constants shared by the forward-difference edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fde_pkg;

  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 9;
  localparam int MAG_W      = 9;
  localparam int SQ_W       = 16;
  localparam int SUM_W      = 17;
  localparam int THR_W      = 9;
  localparam int THR_SQ_W   = 18;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MIN_DIM    = 2;
  localparam int MAX_HEIGHT = 4096;

  // Transaction queue between the front and back ends.
  localparam int QDEPTH   = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  // Square root: nine radicand digit pairs, three per cycle.
  localparam int RAD_W       = 18;
  localparam int REM_W       = 12;
  localparam int ROOT_CYCLES = 3;
  localparam int ROOT_STEPS  = 3;
  localparam int STEP_W      = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0]   THR_RESET    = 9'd30;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] below;
    logic             last;
  } fde_item_t;

  typedef struct packed {
    logic      valid;
    fde_item_t item;
  } fde_slot_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ROOT,
    BK_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/fde_front.sv -----
// ----------------------------------------------------------------------------
// fde_front
// Frame position counters and line buffer: accepts pixels, decides which ones
// complete a centre pixel and hands those on with their neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [fde_pkg::PIX_W-1:0]   in_pixel,
  input  wire logic [fde_pkg::IMG_W_W-1:0] image_width,
  input  wire logic [fde_pkg::IMG_H_W-1:0] image_height,
  input  wire logic                        q_full,
  output fde_pkg::fde_slot_t               slot
);
  import fde_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCMP = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [CW-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               slot_valid_r, slot_valid_nxt;
  logic [PIX_W-1:0]   centre_r, right_r, below_r;
  logic               last_r;

  logic [WCMP-1:0]    width_ext, w_eff, col_ext, col_inc;
  logic [IMG_H_W-1:0] h_eff, row_ext, row_inc;
  logic [CW-1:0]      right_addr;
  logic               accept, emit, last;

  assign in_stall = slot_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    width_ext = WCMP'(image_width);
    if (width_ext < WCMP'(MIN_DIM)) begin
      w_eff = WCMP'(MIN_DIM);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (image_height < IMG_H_W'(MIN_DIM)) begin
      h_eff = IMG_H_W'(MIN_DIM);
    end else if (image_height > IMG_H_W'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign col_ext    = WCMP'(col_r);
  assign col_inc    = col_ext + WCMP'(1);
  assign row_ext    = IMG_H_W'(row_r);
  assign row_inc    = row_ext + IMG_H_W'(1);
  assign right_addr = col_inc[CW-1:0];

  // A centre pixel is complete once the pixel below it arrives, except in
  // the last column; counters beyond a shrunken frame give nothing.
  assign emit = (row_r != '0) && (row_ext <= h_eff - IMG_H_W'(1))
             && (col_ext < w_eff - WCMP'(1));
  assign last = (row_ext == h_eff - IMG_H_W'(1)) && (col_ext == w_eff - WCMP'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_comb begin
    if (accept) begin
      slot_valid_nxt = emit;
    end else if (!q_full) begin
      slot_valid_nxt = 1'b0;
    end else begin
      slot_valid_nxt = slot_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      slot_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      slot_valid_r <= slot_valid_nxt;
    end
  end

  // The reads see the previous row, as the write to the same entry lands
  // at the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col_r] <= in_pixel;
      centre_r        <= line_mem[col_r];
      right_r         <= line_mem[right_addr];
      below_r         <= in_pixel;
      last_r          <= last;
    end
  end

  assign slot.valid       = slot_valid_r;
  assign slot.item.centre = centre_r;
  assign slot.item.right  = right_r;
  assign slot.item.below  = below_r;
  assign slot.item.last   = last_r;

endmodule

`default_nettype wire

// ----- rtl/fde_queue.sv -----
// ----------------------------------------------------------------------------
// fde_queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire fde_pkg::fde_slot_t push_slot,
  output logic              full,
  input  wire logic         pop,
  output fde_pkg::fde_slot_t head
);
  import fde_pkg::*;

  fde_item_t            entry_r [QDEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 push;

  assign full = (count_r == Q_CNT_W'(QDEPTH));
  assign push = push_slot.valid && !full;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_slot.item;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- rtl/fde_back.sv -----
// ----------------------------------------------------------------------------
// fde_back
// Gradient arithmetic: differences, sum of squares, integer square root and
// threshold test, with a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fde_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fde_pkg::fde_slot_t          head,
  output logic                             pop,
  input  wire logic [fde_pkg::THR_W-1:0]   edge_threshold,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [fde_pkg::GRAD_W-1:0] out_grad_down,
  output logic signed [fde_pkg::GRAD_W-1:0] out_grad_right,
  output logic [fde_pkg::MAG_W-1:0]        out_magnitude,
  output logic                             out_is_edge,
  output logic                             out_last_of_frame
);
  import fde_pkg::*;

  back_state_t              state_r, state_nxt;
  logic signed [GRAD_W-1:0] gd_r, gd_nxt, gr_r, gr_nxt;
  logic                     last_r, last_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic [THR_SQ_W-1:0]      thr_sq_r, thr_sq_nxt;
  logic [RAD_W-1:0]         rad_r, rad_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [MAG_W-1:0]         root_r, root_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [GRAD_W-1:0] out_gd_r, out_gd_nxt, out_gr_r, out_gr_nxt;
  logic [MAG_W-1:0]         out_mag_r, out_mag_nxt;
  logic                     out_edge_r, out_edge_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_free;
  logic signed [2*GRAD_W-1:0] sq_d, sq_r;
  logic [RAD_W-1:0]         rad_step;
  logic [REM_W-1:0]         rem_step;
  logic [MAG_W-1:0]         root_step;

  assign out_free = !out_valid_r || !out_stall;
  assign sq_d     = gd_r * gd_r;
  assign sq_r     = gr_r * gr_r;

  // Three digit pairs of the restoring square root per cycle.
  always_comb begin
    logic [RAD_W-1:0] rad_v;
    logic [REM_W-1:0] rem_v;
    logic [REM_W-1:0] trial_v;
    logic [MAG_W-1:0] root_v;
    rad_v  = rad_r;
    rem_v  = rem_r;
    root_v = root_r;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rem_v   = {rem_v[REM_W-3:0], rad_v[RAD_W-1 -: 2]};
      rad_v   = {rad_v[RAD_W-3:0], 2'b00};
      trial_v = REM_W'({root_v, 2'b01});
      if (rem_v >= trial_v) begin
        rem_v  = rem_v - trial_v;
        root_v = {root_v[MAG_W-2:0], 1'b1};
      end else begin
        root_v = {root_v[MAG_W-2:0], 1'b0};
      end
    end
    rad_step  = rad_v;
    rem_step  = rem_v;
    root_step = root_v;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          state_nxt = BK_SQUARE;
        end
      end
      BK_SQUARE: state_nxt = BK_ROOT;
      BK_ROOT: begin
        if (step_r == STEP_W'(ROOT_CYCLES - 1)) begin
          state_nxt = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    gd_nxt       = gd_r;
    gr_nxt       = gr_r;
    last_nxt     = last_r;
    sum_nxt      = sum_r;
    thr_sq_nxt   = thr_sq_r;
    rad_nxt      = rad_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    step_nxt     = step_r;
    out_gd_nxt   = out_gd_r;
    out_gr_nxt   = out_gr_r;
    out_mag_nxt  = out_mag_r;
    out_edge_nxt = out_edge_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      BK_IDLE: begin
        pop      = head.valid;
        gd_nxt   = GRAD_W'({1'b0, head.item.below}) - GRAD_W'({1'b0, head.item.centre});
        gr_nxt   = GRAD_W'({1'b0, head.item.right}) - GRAD_W'({1'b0, head.item.centre});
        last_nxt = head.item.last;
      end
      BK_SQUARE: begin
        sum_nxt    = SUM_W'(sq_d[SQ_W-1:0]) + SUM_W'(sq_r[SQ_W-1:0]);
        thr_sq_nxt = THR_SQ_W'(edge_threshold) * THR_SQ_W'(edge_threshold);
        rad_nxt    = RAD_W'(sum_nxt);
        rem_nxt    = '0;
        root_nxt   = '0;
        step_nxt   = '0;
      end
      BK_ROOT: begin
        rad_nxt  = rad_step;
        rem_nxt  = rem_step;
        root_nxt = root_step;
        step_nxt = step_r + STEP_W'(1);
      end
      BK_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_gd_nxt    = gd_r;
          out_gr_nxt    = gr_r;
          out_mag_nxt   = root_r;
          out_edge_nxt  = THR_SQ_W'(sum_r) > thr_sq_r;
          out_last_nxt  = last_r;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gd_r       <= gd_nxt;
    gr_r       <= gr_nxt;
    last_r     <= last_nxt;
    sum_r      <= sum_nxt;
    thr_sq_r   <= thr_sq_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    out_gd_r   <= out_gd_nxt;
    out_gr_r   <= out_gr_nxt;
    out_mag_r  <= out_mag_nxt;
    out_edge_r <= out_edge_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_grad_down     = out_gd_r;
  assign out_grad_right    = out_gr_r;
  assign out_magnitude     = out_mag_r;
  assign out_is_edge       = out_edge_r;
  assign out_last_of_frame = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/forward_difference_edge_detect.sv -----
// Pixels that complete no centre are taken one per cycle unless a result is
// waiting on a full queue. The back end works on one result at a time,
// through its square, root and hold states, and a four-entry queue absorbs
// bursts of results.
// Reset is synchronous and active low: it clears the frame position, queue
// and output valid and restores the registers; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// forward_difference_edge_detect
// Raster-scan forward-difference gradient, magnitude and edge flag, with a
// one-row line buffer and a plain register write port.
// ----------------------------------------------------------------------------
`default_nettype none

module forward_difference_edge_detect #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [fde_pkg::PIX_W-1:0]      in_pixel,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [fde_pkg::GRAD_W-1:0]   out_grad_down,
  output logic signed [fde_pkg::GRAD_W-1:0]   out_grad_right,
  output logic [fde_pkg::MAG_W-1:0]           out_magnitude,
  output logic                                out_is_edge,
  output logic                                out_last_of_frame,
  input  wire logic                           cfg_we,
  input  wire logic [fde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fde_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fde_pkg::*;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 9'd360;

  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [IMG_W_W-1:0] width_r, width_nxt;
  logic [IMG_H_W-1:0] height_r, height_nxt;

  fde_slot_t front_slot;
  fde_slot_t q_head;
  logic      q_full;
  logic      q_pop;

  always_comb begin
    thr_nxt    = thr_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_nxt    = cfg_data[THR_W-1:0];
        REG_WIDTH:     width_nxt  = cfg_data[IMG_W_W-1:0];
        REG_HEIGHT:    height_nxt = cfg_data[IMG_H_W-1:0];
        default:       thr_nxt    = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      thr_r    <= thr_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  fde_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .image_width  (width_r),
    .image_height (height_r),
    .q_full       (q_full),
    .slot         (front_slot)
  );

  fde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_slot (front_slot),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  fde_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .pop               (q_pop),
    .edge_threshold    (thr_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_grad_down     (out_grad_down),
    .out_grad_right    (out_grad_right),
    .out_magnitude     (out_magnitude),
    .out_is_edge       (out_is_edge),
    .out_last_of_frame (out_last_of_frame)
  );

  // The back end only takes a transaction that the queue actually holds.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("back end popped an empty queue");

  // A zero magnitude comes from, and only from, two zero differences.
  a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_magnitude == '0) == (out_grad_down == '0 && out_grad_right == '0)))
    else $error("magnitude disagrees with the gradients");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude <= MAG_LIMIT))
    else $error("magnitude out of range");

endmodule

`default_nettype wire

// ----- verif/forward_difference_edge_detect_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forward_difference_edge_detect_tb
// Self-checking bench for the raster-scan gradient edge detector. A queue of
// pixels feeds a clocked driver, and a clocked monitor compares each result
// against a gradient predictor that keeps its own line buffer, frame position
// and register copies. Both channels idle at random but for one gap-free run.
// Registers change only once the block has gone quiet.
// ----------------------------------------------------------------------------

module forward_difference_edge_detect_tb;
  import fde_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int DRAIN_CYCLES = 30;
  // Roughly a thousand pixels, with each result holding the back end and with
  // output stalls on top, finish well inside this limit.
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic signed [GRAD_W-1:0] down;
    logic signed [GRAD_W-1:0] right;
    logic [MAG_W-1:0]         mag;
    logic                     edge_flag;
    logic                     frame_end;
  } grad_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic [PIX_W-1:0]         in_pixel   = '0;
  logic                     out_stall  = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index  = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0]    cfg_data   = '0;
  logic                     in_stall;
  logic                     out_valid;
  logic signed [GRAD_W-1:0] out_grad_down;
  logic signed [GRAD_W-1:0] out_grad_right;
  logic [MAG_W-1:0]         out_magnitude;
  logic                     out_is_edge;
  logic                     out_last_of_frame;

  forward_difference_edge_detect #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_grad_down    (out_grad_down),
    .out_grad_right   (out_grad_right),
    .out_magnitude    (out_magnitude),
    .out_is_edge      (out_is_edge),
    .out_last_of_frame(out_last_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: the previous row, the frame position of the next pixel
  // and the register values the block should hold.
  logic [PIX_W-1:0]   line_buf [0:MAX_W-1];
  int unsigned        col_pos    = 0;
  int unsigned        row_pos    = 0;
  logic [THR_W-1:0]   thr_reg    = THR_RESET;
  logic [IMG_W_W-1:0] width_reg  = WIDTH_RESET;
  logic [IMG_H_W-1:0] height_reg = HEIGHT_RESET;

  logic [PIX_W-1:0] pending_pixels [$];
  grad_t            expected_grads [$];
  int unsigned      pixels_sent  = 0;
  int unsigned      pixels_taken = 0;
  int unsigned      mismatches   = 0;
  int unsigned      cycle_count  = 0;
  bit               no_gaps      = 1'b0;

  function automatic int unsigned eff_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < MIN_DIM) return MIN_DIM;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Pixels still to come before the frame position returns to the origin.
  function automatic int unsigned frame_rest();
    int unsigned w;
    int unsigned h;
    w = eff_width();
    h = eff_height();
    if (col_pos == 0 && row_pos == 0) return 0;
    if (row_pos >= h) return w - col_pos;
    return (h - 1 - row_pos) * w + (w - col_pos);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit take_break();
    return !no_gaps && ($urandom_range(0, 99) < 12);
  endfunction

  // One accepted pixel: a result for the centre above it, if that centre
  // has a right neighbour and lies inside the frame.
  task automatic apply_pixel(input logic [PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned sum;
    int unsigned t;
    int          gd;
    int          gr;
    grad_t       g;
    w = eff_width();
    h = eff_height();
    t = thr_reg;
    if (row_pos >= 1 && row_pos <= h - 1 && col_pos < w - 1) begin
      gd = int'(px) - int'(line_buf[col_pos]);
      gr = int'(line_buf[col_pos + 1]) - int'(line_buf[col_pos]);
      sum = gd * gd + gr * gr;
      g.down = gd[GRAD_W-1:0];
      g.right = gr[GRAD_W-1:0];
      g.mag = MAG_W'(root_floor(sum));
      g.edge_flag = (sum > t * t);
      g.frame_end = (row_pos == h - 1 && col_pos == w - 2);
      expected_grads.push_back(g);
    end
    line_buf[col_pos] = px;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    pixels_taken++;
  endtask

  task automatic report(input string name, input logic signed [31:0] want,
                        input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: a stalled transaction is held; otherwise the next pixel is
  // offered unless this cycle is a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_pixel(in_pixel);
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_pixel <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    grad_t g;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grads.size() == 0) begin
          $error("result with nothing expected: grad_down %0d, grad_right %0d",
                 out_grad_down, out_grad_right);
          mismatches++;
        end else begin
          g = expected_grads.pop_front();
          report("grad_down", g.down, out_grad_down);
          report("grad_right", g.right, out_grad_right);
          report("magnitude", g.mag, out_magnitude);
          report("is_edge", g.edge_flag, out_is_edge);
          report("last_of_frame", g.frame_end, out_last_of_frame);
        end
      end
      out_stall <= take_break();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Pixels that complete no centre may still be in the front end when the
  // last result has arrived, hence the extra cycles.
  task automatic settle();
    while (pixels_taken != pixels_sent || expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_THRESHOLD: thr_reg = val[THR_W-1:0];
      REG_WIDTH:     width_reg = val[IMG_W_W-1:0];
      default:       height_reg = val[IMG_H_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned thr, input int unsigned w,
                           input int unsigned h);
    settle();
    set_reg(REG_THRESHOLD, thr);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] p);
    pending_pixels.push_back(p);
    pixels_sent++;
  endtask

  task automatic feed(input int unsigned n);
    for (int i = 0; i < n; i++) push_pixel(rand_pixel());
  endtask

  initial begin
    logic [PIX_W-1:0] directed_px [21];
    // A 3x3 frame with full-scale gradients both ways and a 3-4-5 centre
    // sitting exactly on the threshold, then flat and unit-step 2x2 frames,
    // then a full-scale centre against a threshold above the largest magnitude.
    directed_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd3, 8'd3, 8'd4, 8'd200,
                    8'd7, 8'd7, 8'd7, 8'd7, 8'd0, 8'd0, 8'd1, 8'd0,
                    8'd0, 8'd255, 8'd255, 8'd9};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    configure(5, 3, 3);
    for (int i = 0; i < 9; i++) push_pixel(directed_px[i]);
    // Width and height below the minimum behave as two.
    configure(0, 1, 0);
    for (int i = 9; i < 17; i++) push_pixel(directed_px[i]);
    configure(361, 2, 2);
    for (int i = 17; i < 21; i++) push_pixel(directed_px[i]);

    configure($urandom_range(0, 361), 8, 6);
    feed(3 * 48);

    // Oversized width and height clamp to their maxima; part of the first
    // row goes in, then the width drops below the current column so the row
    // ends early, and the height drops as well.
    configure(511, 4095, 8191);
    feed(40);
    configure(511, 5, 3);
    feed(60);
    settle();
    feed(frame_rest());

    configure($urandom_range(0, 361), 16, 4);
    no_gaps = 1'b1;
    feed(5 * 64);
    settle();
    no_gaps = 1'b0;

    configure($urandom_range(0, 361), 2, 2);
    feed(15 * 4);

    // Mid-frame the height falls below the current row, whose pixels then
    // give no result, and the width shrinks within that row.
    configure($urandom_range(0, 361), 33, 4);
    feed(2 * 33 + 10);
    configure($urandom_range(0, 361), 20, 2);
    settle();
    feed(frame_rest() + 2 * 40);

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fde_pkg.sv
rtl/fde_front.sv
rtl/fde_queue.sv
rtl/fde_back.sv
rtl/forward_difference_edge_detect.sv
verif/forward_difference_edge_detect_tb.sv
